// ===== rtl/timer_table_one_shot_periodic_core_assert.svh =====
// Assertion macros shared by the timer table RTL.
// Each macro expects clk and rst in the scope where it is used.
`ifndef TIMER_TABLE_ONE_SHOT_PERIODIC_CORE_ASSERT_SVH
`define TIMER_TABLE_ONE_SHOT_PERIODIC_CORE_ASSERT_SVH

// condition holds on every clock out of reset
`define TTOP_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("timer table check failed");

// consequent holds in the same cycle as the antecedent
`define TTOP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("timer table check failed");

// consequent holds in the cycle after the antecedent
`define TTOP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("timer table check failed");

`endif

// ===== rtl/ttop_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and helpers for the timer table core.
// No dependencies; used by every other file but the assertion macro header.
package ttop_pkg;

  localparam int MAX_TIMERS = 16;
  localparam int CNT_W      = $clog2(MAX_TIMERS + 1);
  localparam int IDX_W      = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;

  localparam int OP_W    = 2;
  localparam int TIME_W  = 48;
  localparam int DELAY_W = 32;
  localparam int ID_W    = 32;
  localparam int EV_W    = 3;

  localparam logic [ID_W-1:0] ID_FIRST = ID_W'(1);

  typedef enum logic [OP_W-1:0] {
    OP_TICK         = 2'd0,
    OP_ADD_ONCE     = 2'd1,
    OP_ADD_PERIODIC = 2'd2,
    OP_CLEAR        = 2'd3
  } op_t;

  typedef enum logic [EV_W-1:0] {
    EV_ADDED     = 3'd0,
    EV_FIRED     = 3'd1,
    EV_CLEARED   = 3'd2,
    EV_NOT_FOUND = 3'd3,
    EV_FULL      = 3'd4,
    EV_DONE      = 3'd5
  } ev_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ADD,
    ST_CLEAR,
    ST_TICK
  } state_t;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [TIME_W-1:0]  expiry;
    logic [DELAY_W-1:0] interval;
    logic               repeats;
  } slot_t;

  typedef struct packed {
    logic load;
    logic insert;
    logic remove;
    logic rearm;
    logic idx_inc;
    logic emit;
    ev_t  ev;
  } dp_cmd_t;

  typedef struct packed {
    logic full;
    logic at_end;
    logic id_match;
    logic due;
    logic repeats;
    logic out_free;
  } dp_status_t;

  function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] t,
                                                input logic [DELAY_W-1:0] d);
    logic [TIME_W:0] s;
    s = {1'b0, t} + {{(TIME_W + 1 - DELAY_W){1'b0}}, d};
    return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
  endfunction

endpackage

// ===== rtl/ttop_in_if.sv =====
`timescale 1ns / 1ps
// Request channel of the timer table: valid/ready plus one request.
// Depends on ttop_pkg for field widths.
interface ttop_in_if;
  logic                          valid;
  logic                          ready;
  logic [ttop_pkg::OP_W-1:0]     operation;
  logic [ttop_pkg::TIME_W-1:0]   now_ms;
  logic [ttop_pkg::DELAY_W-1:0]  delay_ms;
  logic [ttop_pkg::ID_W-1:0]     clear_id;

  modport source (output valid, operation, now_ms, delay_ms, clear_id, input ready);
  modport sink   (input valid, operation, now_ms, delay_ms, clear_id, output ready);
endinterface

// ===== rtl/ttop_out_if.sv =====
`timescale 1ns / 1ps
// Result channel of the timer table: valid/ready plus one result.
// Depends on ttop_pkg for field widths.
interface ttop_out_if;
  logic                       valid;
  logic                       ready;
  logic [ttop_pkg::EV_W-1:0]  event_res;
  logic [ttop_pkg::ID_W-1:0]  timer_id_res;
  logic                       periodic;
  logic                       last;

  modport source (output valid, event_res, timer_id_res, periodic, last, input ready);
  modport sink   (input valid, event_res, timer_id_res, periodic, last, output ready);
endinterface

// ===== rtl/ttop_dp.sv =====
`timescale 1ns / 1ps
// Datapath: timer slot list, scan index, id counter and result register.
// Depends on ttop_pkg and the assertion macro header.
`include "timer_table_one_shot_periodic_core_assert.svh"
module ttop_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  ttop_pkg::dp_cmd_t             cmd,
  output ttop_pkg::dp_status_t          st,
  input  logic [ttop_pkg::OP_W-1:0]     in_operation,
  input  logic [ttop_pkg::TIME_W-1:0]   in_now_ms,
  input  logic [ttop_pkg::DELAY_W-1:0]  in_delay_ms,
  input  logic [ttop_pkg::ID_W-1:0]     in_clear_id,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ttop_pkg::EV_W-1:0]     event_res,
  output logic [ttop_pkg::ID_W-1:0]     timer_id_res,
  output logic                          periodic,
  output logic                          last
);

  ttop_pkg::op_t                     op_q;
  logic [ttop_pkg::TIME_W-1:0]       now_q;
  logic [ttop_pkg::DELAY_W-1:0]      delay_q;
  logic [ttop_pkg::ID_W-1:0]         cid_q;

  ttop_pkg::slot_t                   slots [ttop_pkg::MAX_TIMERS];
  logic [ttop_pkg::CNT_W-1:0]        count;
  logic [ttop_pkg::CNT_W-1:0]        idx;
  logic [ttop_pkg::ID_W-1:0]         next_id;

  ttop_pkg::slot_t                   cur;
  ttop_pkg::slot_t                   new_slot;
  logic [ttop_pkg::TIME_W-1:0]       rearm_exp;
  logic                              add_rep;
  logic [ttop_pkg::ID_W-1:0]         res_id;
  logic                              res_per;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q    <= ttop_pkg::op_t'(in_operation);
      now_q   <= in_now_ms;
      delay_q <= in_delay_ms;
      cid_q   <= in_clear_id;
    end
  end

  assign cur       = slots[idx[ttop_pkg::IDX_W-1:0]];
  assign add_rep   = (op_q == ttop_pkg::OP_ADD_PERIODIC);
  assign rearm_exp = ttop_pkg::sat_add(now_q, cur.interval);

  always_comb begin
    new_slot.id       = next_id;
    new_slot.expiry   = ttop_pkg::sat_add(now_q, delay_q);
    new_slot.interval = add_rep ? delay_q : '0;
    new_slot.repeats  = add_rep;
  end

  always_comb begin
    st.full     = (count == ttop_pkg::CNT_W'(ttop_pkg::MAX_TIMERS));
    st.at_end   = (idx == count);
    st.id_match = (cur.id == cid_q);
    st.due      = (now_q >= cur.expiry);
    st.repeats  = cur.repeats;
    st.out_free = !out_valid || out_ready;
  end

  // slot list: newest at slot 0, live slots form a prefix
  always_ff @(posedge clk) begin
    if (cmd.insert) begin
      slots[0] <= new_slot;
      for (int j = 1; j < ttop_pkg::MAX_TIMERS; j++) begin
        slots[j] <= slots[j-1];
      end
    end else if (cmd.remove) begin
      for (int j = 0; j < ttop_pkg::MAX_TIMERS - 1; j++) begin
        if (ttop_pkg::CNT_W'(j) >= idx) begin
          slots[j] <= slots[j+1];
        end
      end
    end else if (cmd.rearm) begin
      slots[idx[ttop_pkg::IDX_W-1:0]].expiry <= rearm_exp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      idx     <= '0;
      next_id <= ttop_pkg::ID_FIRST;
    end else begin
      if (cmd.insert) begin
        count   <= count + 1'b1;
        next_id <= (next_id == {ttop_pkg::ID_W{1'b1}}) ? ttop_pkg::ID_FIRST
                                                        : next_id + 1'b1;
      end else if (cmd.remove) begin
        count <= count - 1'b1;
      end
      if (cmd.load) begin
        idx <= '0;
      end else if (cmd.idx_inc) begin
        idx <= idx + 1'b1;
      end
    end
  end

  always_comb begin
    case (cmd.ev)
      ttop_pkg::EV_ADDED: begin
        res_id  = next_id;
        res_per = add_rep;
      end
      ttop_pkg::EV_FIRED: begin
        res_id  = cur.id;
        res_per = cur.repeats;
      end
      ttop_pkg::EV_CLEARED: begin
        res_id  = cid_q;
        res_per = cur.repeats;
      end
      default: begin
        res_id  = '0;
        res_per = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      event_res    <= cmd.ev;
      timer_id_res <= res_id;
      periodic     <= res_per;
      last         <= (cmd.ev != ttop_pkg::EV_FIRED);
    end
  end

  `TTOP_ASSERT_ALWAYS(a_count_bound, count <= ttop_pkg::CNT_W'(ttop_pkg::MAX_TIMERS))
  `TTOP_ASSERT_IMP(a_emit_slot_free, cmd.emit, !out_valid || out_ready)
  `TTOP_ASSERT_IMP(a_insert_room, cmd.insert, !st.full)
  `TTOP_ASSERT_NXT(a_remove_shrinks, cmd.remove && !rst, count == $past(count) - 1'b1)

endmodule

// ===== rtl/ttop_ctrl.sv =====
`timescale 1ns / 1ps
// Controller: sequences add, clear-by-id scan and tick scan over the datapath.
// Depends on ttop_pkg and the assertion macro header.
`include "timer_table_one_shot_periodic_core_assert.svh"
module ttop_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic [ttop_pkg::OP_W-1:0]  in_operation,
  output logic                       in_ready,
  input  ttop_pkg::dp_status_t       st,
  output ttop_pkg::dp_cmd_t          cmd
);

  ttop_pkg::state_t state;
  ttop_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ttop_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ttop_pkg::ST_IDLE: begin
        if (in_valid) begin
          case (ttop_pkg::op_t'(in_operation))
            ttop_pkg::OP_TICK:         state_next = ttop_pkg::ST_TICK;
            ttop_pkg::OP_ADD_ONCE:     state_next = ttop_pkg::ST_ADD;
            ttop_pkg::OP_ADD_PERIODIC: state_next = ttop_pkg::ST_ADD;
            ttop_pkg::OP_CLEAR:        state_next = ttop_pkg::ST_CLEAR;
            default:                   state_next = ttop_pkg::ST_IDLE;
          endcase
        end
      end
      ttop_pkg::ST_ADD: begin
        if (st.out_free) state_next = ttop_pkg::ST_IDLE;
      end
      ttop_pkg::ST_CLEAR: begin
        if ((st.at_end || st.id_match) && st.out_free) state_next = ttop_pkg::ST_IDLE;
      end
      ttop_pkg::ST_TICK: begin
        if (st.at_end && st.out_free) state_next = ttop_pkg::ST_IDLE;
      end
      default: state_next = ttop_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    cmd.ev   = ttop_pkg::EV_DONE;
    case (state)
      ttop_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ttop_pkg::ST_ADD: begin
        if (st.out_free) begin
          cmd.emit = 1'b1;
          if (st.full) begin
            cmd.ev = ttop_pkg::EV_FULL;
          end else begin
            cmd.ev     = ttop_pkg::EV_ADDED;
            cmd.insert = 1'b1;
          end
        end
      end
      ttop_pkg::ST_CLEAR: begin
        if (st.at_end) begin
          cmd.ev   = ttop_pkg::EV_NOT_FOUND;
          cmd.emit = st.out_free;
        end else if (st.id_match) begin
          cmd.ev     = ttop_pkg::EV_CLEARED;
          cmd.emit   = st.out_free;
          cmd.remove = st.out_free;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      ttop_pkg::ST_TICK: begin
        if (st.at_end) begin
          cmd.ev   = ttop_pkg::EV_DONE;
          cmd.emit = st.out_free;
        end else if (st.due) begin
          cmd.ev = ttop_pkg::EV_FIRED;
          if (st.out_free) begin
            cmd.emit = 1'b1;
            if (st.repeats) begin
              cmd.rearm   = 1'b1;
              cmd.idx_inc = 1'b1;
            end else begin
              cmd.remove = 1'b1;
            end
          end
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  `TTOP_ASSERT_NXT(a_accept_leaves_idle, state == ttop_pkg::ST_IDLE && in_valid,
                   state != ttop_pkg::ST_IDLE)
  `TTOP_ASSERT_IMP(a_remove_in_range, cmd.remove, !st.at_end)
  `TTOP_ASSERT_IMP(a_one_list_update, cmd.insert || cmd.remove || cmd.rearm,
                   $onehot({cmd.insert, cmd.remove, cmd.rearm}))

endmodule

// ===== rtl/timer_table_one_shot_periodic_core.sv =====
`timescale 1ns / 1ps
// Timer table top level. Add and clear give one result; after acceptance an add's result
// is registered from ST_ADD, and a clear passes over non-matching slots in ST_CLEAR first.
// A tick walks the live slots one per cycle, but waits on a due slot or its done result
// while the result channel holds off ready.
// One request is in work at a time; the scan of the shared slot list sets the rate.
// Synchronous reset empties the table and sets the next id to 1.
module timer_table_one_shot_periodic_core (
  input  logic       clk,
  input  logic       rst,
  ttop_in_if.sink    timer_in,
  ttop_out_if.source timer_out
);

  ttop_pkg::dp_cmd_t    cmd;
  ttop_pkg::dp_status_t st;

  ttop_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (timer_in.valid),
    .in_operation (timer_in.operation),
    .in_ready     (timer_in.ready),
    .st           (st),
    .cmd          (cmd)
  );

  ttop_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .st           (st),
    .in_operation (timer_in.operation),
    .in_now_ms    (timer_in.now_ms),
    .in_delay_ms  (timer_in.delay_ms),
    .in_clear_id  (timer_in.clear_id),
    .out_valid    (timer_out.valid),
    .out_ready    (timer_out.ready),
    .event_res    (timer_out.event_res),
    .timer_id_res (timer_out.timer_id_res),
    .periodic     (timer_out.periodic),
    .last         (timer_out.last)
  );

endmodule
